// ===== rtl/core/mmc3_pkg.sv =====
// Shared codes and widths for the MMC3-style bank mapper.
package mmc3_pkg;

    localparam int ACTION_W = 3;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int TARGET_W = 3;
    localparam int INDEX_W  = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int BANK_W   = 8;
    localparam int COUNT_W  = 9;

    localparam logic [ACTION_W-1:0] ACT_CPU_RD = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CPU_WR = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PPU_RD = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PPU_WR = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_NT_MAP = 3'd4;

    localparam logic [TARGET_W-1:0] TGT_NONE    = 3'd0;
    localparam logic [TARGET_W-1:0] TGT_PRG_ROM = 3'd1;
    localparam logic [TARGET_W-1:0] TGT_PRG_RAM = 3'd2;
    localparam logic [TARGET_W-1:0] TGT_CHR_ROM = 3'd3;
    localparam logic [TARGET_W-1:0] TGT_CHR_RAM = 3'd4;
    localparam logic [TARGET_W-1:0] TGT_NAMETBL = 3'd5;

    localparam logic [2:0] REG_BANK_SEL  = 3'd0;
    localparam logic [2:0] REG_BANK_DATA = 3'd1;
    localparam logic [2:0] REG_MIRROR    = 3'd2;
    localparam logic [2:0] REG_RAM_CTRL  = 3'd3;
    localparam logic [2:0] REG_IRQ_PERIOD = 3'd4;
    localparam logic [2:0] REG_IRQ_REARM = 3'd5;
    localparam logic [2:0] REG_IRQ_OFF   = 3'd6;
    localparam logic [2:0] REG_IRQ_ON    = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_FIX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VERT = 3'd4;

    typedef enum logic [1:0] {
        BSRC_NONE,
        BSRC_PRG,
        BSRC_CHR,
        BSRC_CHR_INC
    } t_bank_src;

endpackage

// ===== rtl/core/mmc3_bank_mapper_irq.sv =====
// Bank mapper with scanline IRQ counter: one access word in, one mapping word out.
// An accepted word runs through the S_DIV steps of the 8-step shared remainder unit,
// which reduces the bank number modulo the bank count, then waits in S_OUT to load
// the output register; a new word is taken only after the last one leaves S_OUT.
// Output register holds a finished word until taken; S_OUT waits while it is full.
// Synchronous active-low reset loads power-on mapper and configuration state.
module mmc3_bank_mapper_irq #(
    parameter int MAX_PRG_BANKS = 64,
    parameter int MAX_CHR_BANKS = 256,
    parameter int A12_LOW_MIN   = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mmc3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mmc3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [mmc3_pkg::ACTION_W-1:0]      i_action,
    input  logic [mmc3_pkg::ADDR_W-1:0]        i_address,
    input  logic [mmc3_pkg::DATA_W-1:0]        i_write_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [mmc3_pkg::TARGET_W-1:0]      o_target,
    output logic [mmc3_pkg::INDEX_W-1:0]       o_mem_index,
    output logic                               o_mem_write,
    output logic [mmc3_pkg::DATA_W-1:0]        o_out_value,
    output logic                               o_irq_line
);
    import mmc3_pkg::*;

    localparam int RUN_W = $clog2(A12_LOW_MIN + 1);
    localparam logic [RUN_W-1:0] RUN_MIN = RUN_W'(A12_LOW_MIN);
    localparam logic [COUNT_W-1:0] PRG_MAX = COUNT_W'(MAX_PRG_BANKS);
    localparam logic [COUNT_W-1:0] CHR_MAX = COUNT_W'(MAX_CHR_BANKS);
    localparam int STEP_W = $clog2(BANK_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BANK_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [6:0]         r_prg_count;
    logic [COUNT_W-1:0] r_chr_count;
    logic               r_chr_is_ram;
    logic               r_mirror_fixed;

    // mapper state
    logic [2:0]         r_bank_select;
    logic               r_prg_layout;
    logic               r_chr_layout;
    logic [BANK_W-1:0]  r_bank_regs [8];
    logic               r_mirror_h;
    logic               r_ram_enable;
    logic               r_ram_protect;
    logic [7:0]         r_irq_period;
    logic [7:0]         r_irq_count;
    logic               r_irq_rearm;
    logic               r_irq_enable;
    logic               r_irq_flag;
    logic               r_prev_a12;
    logic [RUN_W-1:0]   r_a12_low_run;

    // item in flight
    logic [TARGET_W-1:0] r_target;
    logic                r_wr;
    logic [DATA_W-1:0]   r_value;
    logic [INDEX_W-1:0]  r_index_fix;
    logic [12:0]         r_low;
    t_bank_src           r_bsrc;

    // remainder unit
    logic [BANK_W-1:0]   r_dvd;
    logic [COUNT_W-1:0]  r_div;
    logic [COUNT_W-1:0]  r_rem;
    logic [STEP_W-1:0]   r_step;

    // output register
    logic                r_out_valid;
    logic [TARGET_W-1:0] r_out_target;
    logic [INDEX_W-1:0]  r_out_index;
    logic                r_out_write;
    logic [DATA_W-1:0]   r_out_value;
    logic                r_out_irq;

    logic               w_accept;
    logic               w_cfg_accept;
    logic               w_out_load;
    logic [COUNT_W-1:0] w_prg_raw;
    logic [COUNT_W-1:0] w_prg_n;
    logic [COUNT_W-1:0] w_chr_n;
    logic [1:0]         w_prg_slot;
    logic [2:0]         w_chr_slot;
    logic [2:0]         w_rd_addr;
    logic [BANK_W-1:0]  w_rd_data;
    logic [BANK_W-1:0]  w_prg_nm1;
    logic [BANK_W-1:0]  w_prg_nm2;
    logic [BANK_W-1:0]  n_dvd;
    logic [COUNT_W-1:0] n_div;
    t_bank_src          n_bsrc;
    logic [TARGET_W-1:0] n_target;
    logic               n_wr;
    logic [INDEX_W-1:0] n_index_fix;
    logic               w_in_pattern;
    logic [COUNT_W-1:0] w_trial;
    logic [COUNT_W-1:0] n_rem;
    logic [COUNT_W-1:0] w_inc;
    logic [BANK_W-1:0]  w_bank;
    logic [INDEX_W-1:0] n_out_index;
    logic               w_a12;
    logic               w_a12_clock;
    logic [7:0]         n_irq_count;
    logic               w_reload_hit;
    logic [2:0]         w_reg_code;

    assign o_ready      = (r_state == S_IDLE);
    assign o_cfg_ready  = (r_state == S_IDLE) && !r_out_valid && !i_valid;
    assign w_accept     = i_valid && o_ready;
    assign w_cfg_accept = i_cfg_valid && o_cfg_ready;
    assign w_out_load   = (r_state == S_OUT) && (!r_out_valid || i_ready);

    assign o_valid     = r_out_valid;
    assign o_target    = r_out_target;
    assign o_mem_index = r_out_index;
    assign o_mem_write = r_out_write;
    assign o_out_value = r_out_value;
    assign o_irq_line  = r_out_irq;

    // bank counts
    always_comb begin
        w_prg_raw = {2'b00, r_prg_count};
        if (w_prg_raw < 9'd2) begin
            w_prg_n = 9'd2;
        end else if (w_prg_raw > PRG_MAX) begin
            w_prg_n = PRG_MAX;
        end else begin
            w_prg_n = w_prg_raw;
        end
        if (r_chr_is_ram) begin
            w_chr_n = 9'd8;
        end else if (r_chr_count < 9'd1) begin
            w_chr_n = 9'd1;
        end else if (r_chr_count > CHR_MAX) begin
            w_chr_n = CHR_MAX;
        end else begin
            w_chr_n = r_chr_count;
        end
        w_prg_nm1 = BANK_W'(w_prg_n - 9'd1);
        w_prg_nm2 = BANK_W'(w_prg_n - 9'd2);
    end

    // decode of the incoming word
    always_comb begin
        w_prg_slot   = i_address[14:13];
        w_chr_slot   = i_address[12:10] ^ {r_chr_layout, 2'b00};
        w_in_pattern = (i_address < 16'h2000);
        if (i_action == ACT_CPU_RD) begin
            w_rd_addr = (w_prg_slot == 2'd1) ? 3'd7 : 3'd6;
        end else if (!w_chr_slot[2]) begin
            w_rd_addr = {2'b00, w_chr_slot[1]};
        end else begin
            w_rd_addr = w_chr_slot - 3'd2;
        end
        w_rd_data = r_bank_regs[w_rd_addr];

        n_target    = TGT_NONE;
        n_wr        = 1'b0;
        n_index_fix = '0;
        n_bsrc      = BSRC_NONE;
        n_div       = w_chr_n;
        if (!w_chr_slot[2]) begin
            n_dvd = {w_rd_data[7:1], 1'b0};
        end else begin
            n_dvd = w_rd_data;
        end

        case (i_action)
            ACT_CPU_RD: begin
                n_div = w_prg_n;
                case (w_prg_slot)
                    2'd0: n_dvd = r_prg_layout ? w_prg_nm2 : w_rd_data;
                    2'd1: n_dvd = w_rd_data;
                    2'd2: n_dvd = r_prg_layout ? w_rd_data : w_prg_nm2;
                    default: n_dvd = w_prg_nm1;
                endcase
                if (i_address[15]) begin
                    n_target = TGT_PRG_ROM;
                    n_bsrc   = BSRC_PRG;
                end else if (i_address >= 16'h6000 && r_ram_enable) begin
                    n_target    = TGT_PRG_RAM;
                    n_index_fix = {6'd0, i_address[12:0]};
                end
            end
            ACT_CPU_WR: begin
                if (!i_address[15] && i_address >= 16'h6000 && r_ram_enable
                        && !r_ram_protect) begin
                    n_target    = TGT_PRG_RAM;
                    n_index_fix = {6'd0, i_address[12:0]};
                    n_wr        = 1'b1;
                end
            end
            ACT_PPU_RD: begin
                if (w_in_pattern) begin
                    n_target = r_chr_is_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
                    n_bsrc   = (!w_chr_slot[2] && w_chr_slot[0]) ? BSRC_CHR_INC : BSRC_CHR;
                end
            end
            ACT_PPU_WR: begin
                if (w_in_pattern && r_chr_is_ram) begin
                    n_target = TGT_CHR_RAM;
                    n_wr     = 1'b1;
                    n_bsrc   = (!w_chr_slot[2] && w_chr_slot[0]) ? BSRC_CHR_INC : BSRC_CHR;
                end
            end
            ACT_NT_MAP: begin
                n_target    = TGT_NAMETBL;
                n_index_fix = {8'd0, (r_mirror_h ? i_address[11] : i_address[10]),
                               i_address[9:0]};
            end
            default: begin
                n_target = TGT_NONE;
            end
        endcase
    end

    // remainder step and final index
    always_comb begin
        w_trial = {r_rem[7:0], r_dvd[BANK_W-1]};
        n_rem   = (w_trial >= r_div) ? (w_trial - r_div) : w_trial;
        w_inc   = r_rem + 9'd1;
        w_bank  = (w_inc == r_div) ? '0 : w_inc[7:0];
        case (r_bsrc)
            BSRC_PRG:     n_out_index = {r_rem[5:0], r_low};
            BSRC_CHR:     n_out_index = {1'b0, r_rem[7:0], r_low[9:0]};
            BSRC_CHR_INC: n_out_index = {1'b0, w_bank, r_low[9:0]};
            default:      n_out_index = r_index_fix;
        endcase
    end

    // scanline counter
    always_comb begin
        w_a12        = i_address[12];
        w_a12_clock  = w_a12 && !r_prev_a12 && (r_a12_low_run >= RUN_MIN);
        w_reload_hit = (r_irq_count == 8'd0) || r_irq_rearm;
        n_irq_count  = w_reload_hit ? r_irq_period : (r_irq_count - 8'd1);
        w_reg_code   = {i_address[14:13], i_address[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_prg_count        <= 7'd2;
            r_chr_count        <= 9'd8;
            r_chr_is_ram       <= 1'b0;
            r_mirror_fixed     <= 1'b0;
            r_bank_select      <= '0;
            r_prg_layout       <= 1'b0;
            r_chr_layout       <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_bank_regs[i] <= (i == 7) ? BANK_W'(1) : '0;
            end
            r_mirror_h         <= 1'b0;
            r_ram_enable       <= 1'b0;
            r_ram_protect      <= 1'b0;
            r_irq_period       <= '0;
            r_irq_count        <= '0;
            r_irq_rearm        <= 1'b0;
            r_irq_enable       <= 1'b0;
            r_irq_flag         <= 1'b0;
            r_prev_a12         <= 1'b0;
            r_a12_low_run      <= '0;
            r_out_valid        <= 1'b0;
            r_step             <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_target    <= n_target;
                        r_wr        <= n_wr;
                        r_value     <= n_wr ? i_write_value : '0;
                        r_index_fix <= n_index_fix;
                        r_low       <= i_address[12:0];
                        r_bsrc      <= n_bsrc;
                        r_dvd       <= n_dvd;
                        r_div       <= n_div;
                        r_rem       <= '0;
                        r_step      <= '0;
                        r_state     <= S_DIV;

                        if (i_action == ACT_CPU_WR && i_address[15]) begin
                            case (w_reg_code)
                                REG_BANK_SEL: begin
                                    r_bank_select <= i_write_value[2:0];
                                    r_prg_layout  <= i_write_value[6];
                                    r_chr_layout  <= i_write_value[7];
                                end
                                REG_BANK_DATA: r_bank_regs[r_bank_select] <= i_write_value;
                                REG_MIRROR: begin
                                    if (!r_mirror_fixed) begin
                                        r_mirror_h <= i_write_value[0];
                                    end
                                end
                                REG_RAM_CTRL: begin
                                    r_ram_enable  <= i_write_value[7];
                                    r_ram_protect <= i_write_value[6];
                                end
                                REG_IRQ_PERIOD: r_irq_period <= i_write_value;
                                REG_IRQ_REARM:  r_irq_rearm  <= 1'b1;
                                REG_IRQ_OFF: begin
                                    r_irq_enable <= 1'b0;
                                    r_irq_flag   <= 1'b0;
                                end
                                default: r_irq_enable <= 1'b1;
                            endcase
                        end

                        if (i_action == ACT_PPU_RD && w_in_pattern) begin
                            r_prev_a12 <= w_a12;
                            if (!w_a12) begin
                                if (r_a12_low_run < RUN_MIN) begin
                                    r_a12_low_run <= r_a12_low_run + RUN_W'(1);
                                end
                            end else begin
                                r_a12_low_run <= '0;
                                if (w_a12_clock) begin
                                    r_irq_count <= n_irq_count;
                                    if (w_reload_hit) begin
                                        r_irq_rearm <= 1'b0;
                                    end
                                    if (n_irq_count == 8'd0 && r_irq_enable) begin
                                        r_irq_flag <= 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_dvd  <= {r_dvd[BANK_W-2:0], 1'b0};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_LAST) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_target <= r_target;
                        r_out_index  <= n_out_index;
                        r_out_write  <= r_wr;
                        r_out_value  <= r_value;
                        r_out_irq    <= r_irq_flag;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_cfg_accept) begin
                case (i_cfg_index)
                    CFG_PRG_COUNT:   r_prg_count    <= i_cfg_data[6:0];
                    CFG_CHR_COUNT:   r_chr_count    <= i_cfg_data;
                    CFG_CHR_IS_RAM:  r_chr_is_ram   <= i_cfg_data[0];
                    CFG_MIRROR_FIX:  r_mirror_fixed <= i_cfg_data[0];
                    CFG_HEADER_VERT: r_mirror_h     <= !i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule
